>>> rtl/grouped_bitmap_block_allocator_core_defines.svh
// Assertion macros shared by the allocator RTL.
// Used by files that check their own sequencer; needs clk and rst in scope.
`ifndef GROUPED_BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define GROUPED_BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
// same-cycle implication
`define GBBA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define GBBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/gbba_pkg.sv
// Package for the grouped bitmap block allocator: word types, codes, widths.
// No dependencies.
`timescale 1ns / 1ps
package gbba_pkg;
  localparam int BLK_W   = 14;
  localparam int WANT_W  = 16;
  localparam int GRANT_W = 11;
  localparam int GCNT_W  = 4;
  localparam int BPG_W   = 11;
  localparam int CFG_W   = 14;
  localparam int CIDX_W  = 2;
  localparam int ARITH_W = 20;
  localparam int DIV_STEPS = BLK_W;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVAL   = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_DFREE   = 2'd3
  } status_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CIDX_W-1:0] CFG_GROUP_COUNT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_BPG         = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_FIRST_DATA  = 2'd3;

  localparam logic [GCNT_W-1:0] RST_GROUP_COUNT = 4'd8;
  localparam logic [BPG_W-1:0]  RST_BPG         = 11'd1024;
  localparam logic [BLK_W-1:0]  RST_BLOCK_COUNT = 14'd8192;
  localparam logic              RST_FIRST_DATA  = 1'b0;

  typedef struct packed {
    logic              op;
    logic [BLK_W-1:0]  goal;
    logic [WANT_W-1:0] want;
    logic [BLK_W-1:0]  free_start;
    logic [BLK_W-1:0]  free_count;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [BLK_W-1:0]   first_block;
    logic [GRANT_W-1:0] granted;
    logic [BLK_W-1:0]   free_total;
  } res_t;

  typedef struct packed {
    logic             go;
    logic [BLK_W-1:0] dividend;
    logic [BPG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [BLK_W-1:0] quot;
    logic [BPG_W-1:0] rem;
  } div_rsp_t;
endpackage

>>> rtl/gbba_div.sv
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// Depends on gbba_pkg.
`timescale 1ns / 1ps
module gbba_div (
  input  logic               clk,
  input  logic               rst,
  input  gbba_pkg::div_req_t req,
  output gbba_pkg::div_rsp_t rsp
);
  localparam int QW = gbba_pkg::BLK_W;
  localparam int RW = gbba_pkg::BPG_W;
  localparam int CW = $clog2(gbba_pkg::DIV_STEPS + 1);

  logic [CW-1:0] cnt;
  logic [QW-1:0] quot;
  logic [RW-1:0] rem;
  logic [RW-1:0] dvs;
  logic          done;
  logic [RW:0]   trial;

  assign trial = {rem, quot[QW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        cnt  <= CW'(gbba_pkg::DIV_STEPS);
        quot <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (trial >= {1'b0, dvs}) begin
          rem  <= RW'(trial - {1'b0, dvs});
          quot <= {quot[QW-2:0], 1'b1};
        end else begin
          rem  <= trial[RW-1:0];
          quot <= {quot[QW-2:0], 1'b0};
        end
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;
endmodule

>>> rtl/gbba_bitmap.sv
// Block bitmap storage: one write port, one read port, registered read data.
// No package dependencies.
`timescale 1ns / 1ps
module gbba_bitmap #(
  parameter int AW = 7,
  parameter int WB = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [WB-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [WB-1:0] rdata
);
  logic [WB-1:0] mem [1 << AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/grouped_bitmap_block_allocator_core.sv
// Allocation: setup, division in the shared divider, then a read and a check of each
// bitmap word visited across the groups scanned, plus a write per word of the claimed run.
// Free: setup, division, then a check pass and a clear pass per word. Result strobe follows.
// One word in flight at a time; busy is high until the result strobe.
// After reset the bitmap is cleared one row per cycle (128 rows at default size);
// busy stays high meanwhile, configuration writes are taken throughout.
`timescale 1ns / 1ps
`include "grouped_bitmap_block_allocator_core_defines.svh"
module grouped_bitmap_block_allocator_core #(
  parameter int MAX_GROUPS       = 8,
  parameter int GROUP_BLOCKS_MAX = 1024,
  parameter int WORD_BITS        = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  gbba_pkg::cmd_t                    cmd,
  output logic                              done,
  output gbba_pkg::res_t                    result,
  input  logic                              cfg_we,
  input  logic [gbba_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [gbba_pkg::CFG_W-1:0]        cfg_wdata
);
  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int OW = $clog2(GROUP_BLOCKS_MAX);
  localparam int PW = OW + 1;
  localparam int LW = $clog2(WORD_BITS);
  localparam int MW = GW + OW - LW;
  localparam int AW = gbba_pkg::ARITH_W;
  localparam int BW = gbba_pkg::BLK_W;
  localparam int DW = gbba_pkg::BPG_W;
  localparam int NW = GW + 1;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_ADIV, S_ADIVW, S_AMOD, S_AMODW, S_GSET, S_SRD, S_SCHK,
    S_RUN, S_RRD, S_FDIV, S_FDIVW, S_FSET, S_FRD, S_FCHK, S_FIN
  } state_t;

  state_t state;

  // configuration
  logic [gbba_pkg::GCNT_W-1:0] gcnt;
  logic [DW-1:0]               bpgr;
  logic [BW-1:0]               bcnt;
  logic                        fdb;

  // counters
  logic [PW-1:0] group_used [MAX_GROUPS];
  logic [BW-1:0] used_total;

  // sequencer registers
  logic [MW-1:0]      clr_addr;
  gbba_pkg::cmd_t     cmdr;
  logic [GW-1:0]      g;
  logic [NW-1:0]      n;
  logic [PW-1:0]      pos, e, limit, from, need, got, idx, here;
  logic               pass, phase;
  logic [BW-1:0]      gfr, cnt;
  gbba_pkg::status_t  st;
  logic [BW-1:0]      fb;
  logic [PW-1:0]      gr;

  // bitmap port
  logic          we;
  logic [MW-1:0] waddr, raddr;
  logic [WORD_BITS-1:0] wdata, rdata;

  gbba_pkg::div_req_t dreq;
  gbba_pkg::div_rsp_t drsp;

  gbba_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  gbba_bitmap #(
    .AW (MW),
    .WB (WORD_BITS)
  ) u_bitmap (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // effective geometry
  logic [NW-1:0] ng;
  logic [DW-1:0] bpg;
  logic [AW-1:0] gf_c, rem_c, size_c, span_c, cap_c, fend_c;
  logic [PW-1:0] size_p, gu;
  logic          gfree_zero;
  logic [BW-1:0] ftot;
  logic          last_grp;

  always_comb begin
    if (gcnt == '0) begin
      ng = NW'(1);
    end else if (32'(gcnt) > MAX_GROUPS) begin
      ng = NW'(MAX_GROUPS);
    end else begin
      ng = NW'(gcnt);
    end
    if (bpgr == '0) begin
      bpg = DW'(1);
    end else if (32'(bpgr) > GROUP_BLOCKS_MAX) begin
      bpg = DW'(GROUP_BLOCKS_MAX);
    end else begin
      bpg = bpgr;
    end
  end

  assign gf_c   = AW'(fdb) + AW'(g) * AW'(bpg);
  assign rem_c  = AW'(bcnt) - gf_c;
  assign size_c = (AW'(bcnt) > gf_c) ? ((rem_c < AW'(bpg)) ? rem_c : AW'(bpg)) : '0;
  assign size_p = PW'(size_c);
  assign gu     = group_used[g];
  assign gfree_zero = size_p <= gu;
  assign span_c = AW'(ng) * AW'(bpg);
  assign cap_c  = (bcnt > BW'(fdb)) ?
                  (((AW'(bcnt) - AW'(fdb)) < span_c) ? AW'(bcnt) - AW'(fdb) : span_c) : '0;
  assign ftot   = (cap_c > AW'(used_total)) ? BW'(cap_c - AW'(used_total)) : '0;
  assign fend_c = ((AW'(fdb) + span_c) < AW'(bcnt)) ? AW'(fdb) + span_c : AW'(bcnt);
  assign last_grp = (n + NW'(1)) == ng;

  // word-level scan logic
  logic [LW-1:0]        lo;
  logic [PW-1:0]        wbase;
  logic [PW:0]          nxt;
  logic [WORD_BITS-1:0] in_rng, fmask, setm;
  logic                 f_any, s_any;
  logic [LW-1:0]        f_idx;
  logic [LW:0]          s_idx, run_n;
  logic [PW-1:0]        got_next, need_next;

  always_comb begin
    logic [PW:0] kpos;
    logic        stop;
    lo     = pos[LW-1:0];
    wbase  = {pos[PW-1:LW], {LW{1'b0}}};
    nxt    = (PW+1)'(wbase) + (PW+1)'(WORD_BITS);
    in_rng = '0;
    setm   = '0;
    f_any  = 1'b0;
    f_idx  = '0;
    s_any  = 1'b0;
    s_idx  = (LW+1)'(WORD_BITS);
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      kpos = (PW+1)'(wbase) + (PW+1)'(k);
      in_rng[k] = ((LW+1)'(k) >= (LW+1)'(lo)) && (kpos < (PW+1)'(e));
      stop = ((LW+1)'(k) >= (LW+1)'(lo)) &&
             (rdata[k] || (kpos >= (PW+1)'(limit)) ||
              (((PW+1)'(k) - (PW+1)'(lo)) >= (PW+1)'(need)));
      if (stop) begin
        s_any = 1'b1;
        s_idx = (LW+1)'(k);
      end
    end
    fmask = in_rng & ~rdata;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (fmask[k]) begin
        f_any = 1'b1;
        f_idx = LW'(k);
      end
      if (((LW+1)'(k) >= (LW+1)'(lo)) && ((LW+1)'(k) < s_idx)) begin
        setm[k] = 1'b1;
      end
    end
    run_n     = s_idx - (LW+1)'(lo);
    got_next  = got + PW'(run_n);
    need_next = need - PW'(run_n);
  end

  // bitmap port drive
  always_comb begin
    raddr = {g, pos[OW-1:LW]};
    waddr = raddr;
    wdata = rdata | setm;
    we    = 1'b0;
    unique case (state)
      S_CLR: begin
        waddr = clr_addr;
        wdata = '0;
        we    = 1'b1;
      end
      S_RUN: we = 1'b1;
      S_FCHK: begin
        wdata = rdata & ~in_rng;
        we    = phase;
      end
      default: we = 1'b0;
    endcase
  end

  // divider requests; the group wrap reduces the held goal quotient modulo the group count
  always_comb begin
    dreq.go       = (state == S_ADIV) || (state == S_AMOD) || (state == S_FDIV);
    dreq.divisor  = bpg;
    dreq.dividend = cmdr.goal - BW'(fdb);
    unique case (state)
      S_AMOD: begin
        dreq.dividend = drsp.quot;
        dreq.divisor  = DW'(ng);
      end
      S_FDIV: dreq.dividend = cmdr.free_start - BW'(fdb);
      default: dreq.divisor = bpg;
    endcase
  end

  assign busy = state != S_IDLE;

  logic [PW-1:0] here_c;
  assign here_c = (AW'(cnt) < AW'(size_p - idx)) ? PW'(cnt) : size_p - idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_addr   <= '0;
      used_total <= '0;
      done       <= 1'b0;
      gcnt       <= gbba_pkg::RST_GROUP_COUNT;
      bpgr       <= gbba_pkg::RST_BPG;
      bcnt       <= gbba_pkg::RST_BLOCK_COUNT;
      fdb        <= gbba_pkg::RST_FIRST_DATA;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        group_used[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          gbba_pkg::CFG_GROUP_COUNT: gcnt <= cfg_wdata[gbba_pkg::GCNT_W-1:0];
          gbba_pkg::CFG_BPG:         bpgr <= cfg_wdata[DW-1:0];
          gbba_pkg::CFG_BLOCK_COUNT: bcnt <= cfg_wdata[BW-1:0];
          gbba_pkg::CFG_FIRST_DATA:  fdb  <= cfg_wdata[0];
          default:                   fdb  <= fdb;
        endcase
      end
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmdr  <= cmd;
            st    <= gbba_pkg::ST_OK;
            fb    <= '0;
            gr    <= '0;
            got   <= '0;
            n     <= '0;
            g     <= '0;
            from  <= '0;
            cnt   <= cmd.free_count;
            need  <= (32'(cmd.want) > GROUP_BLOCKS_MAX) ? PW'(GROUP_BLOCKS_MAX) : PW'(cmd.want);
            if (cmd.op == gbba_pkg::OP_ALLOC) begin
              if (cmd.want == '0) begin
                st    <= gbba_pkg::ST_INVAL;
                state <= S_FIN;
              end else if (ftot == '0) begin
                st    <= gbba_pkg::ST_NOSPACE;
                state <= S_FIN;
              end else if ((cmd.goal >= BW'(fdb)) && (cmd.goal < bcnt)) begin
                state <= S_ADIV;
              end else begin
                state <= S_GSET;
              end
            end else begin
              if (cmd.free_count == '0) begin
                state <= S_FIN;
              end else if ((cmd.free_start < BW'(fdb)) ||
                           ((AW'(cmd.free_start) + AW'(cmd.free_count)) > fend_c)) begin
                st    <= gbba_pkg::ST_INVAL;
                state <= S_FIN;
              end else begin
                state <= S_FDIV;
              end
            end
          end
        end
        S_ADIV: state <= S_ADIVW;
        S_ADIVW: begin
          if (drsp.done) begin
            // goal group lies within the group count: start there at the goal offset
            if (AW'(drsp.quot) < AW'(ng)) begin
              g     <= GW'(drsp.quot);
              from  <= PW'(drsp.rem);
              state <= S_GSET;
            end else begin
              state <= S_AMOD;
            end
          end
        end
        S_AMOD: state <= S_AMODW;
        S_AMODW: begin
          if (drsp.done) begin
            g     <= GW'(drsp.rem);
            state <= S_GSET;
          end
        end
        S_GSET: begin
          if (gfree_zero) begin
            if (last_grp) begin
              st    <= gbba_pkg::ST_NOSPACE;
              state <= S_FIN;
            end else begin
              n    <= n + NW'(1);
              g    <= ((NW'(g) + NW'(1)) == ng) ? '0 : g + 1'b1;
              from <= '0;
            end
          end else begin
            limit <= size_p;
            gfr   <= BW'(gf_c);
            pos   <= from;
            e     <= size_p;
            pass  <= 1'b0;
            state <= S_SRD;
          end
        end
        S_SRD: state <= S_SCHK;
        S_SCHK: begin
          if (f_any) begin
            pos   <= wbase + PW'(f_idx);
            fb    <= gfr + BW'(wbase) + BW'(f_idx);
            state <= S_RUN;
          end else if (nxt >= (PW+1)'(e)) begin
            if (!pass && (from != '0)) begin
              // wrap: scan the group head up to the goal offset
              pass  <= 1'b1;
              e     <= from;
              pos   <= '0;
              state <= S_SRD;
            end else if (last_grp) begin
              st    <= gbba_pkg::ST_NOSPACE;
              state <= S_FIN;
            end else begin
              n     <= n + NW'(1);
              g     <= ((NW'(g) + NW'(1)) == ng) ? '0 : g + 1'b1;
              from  <= '0;
              state <= S_GSET;
            end
          end else begin
            pos   <= PW'(nxt);
            state <= S_SRD;
          end
        end
        S_RUN: begin
          got  <= got_next;
          need <= need_next;
          if (!s_any && (need_next != '0) && (nxt < (PW+1)'(limit))) begin
            pos   <= PW'(nxt);
            state <= S_RRD;
          end else begin
            group_used[g] <= gu + got_next;
            used_total    <= used_total + BW'(got_next);
            gr            <= got_next;
            state         <= S_FIN;
          end
        end
        S_RRD: state <= S_RUN;
        S_FDIV: state <= S_FDIVW;
        S_FDIVW: begin
          if (drsp.done) begin
            g     <= GW'(drsp.quot);
            idx   <= PW'(drsp.rem);
            state <= S_FSET;
          end
        end
        S_FSET: begin
          here  <= here_c;
          pos   <= idx;
          e     <= idx + here_c;
          phase <= 1'b0;
          state <= S_FRD;
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (!phase) begin
            if (f_any) begin
              st    <= gbba_pkg::ST_DFREE;
              state <= S_FIN;
            end else if (nxt >= (PW+1)'(e)) begin
              phase <= 1'b1;
              pos   <= idx;
              state <= S_FRD;
            end else begin
              pos   <= PW'(nxt);
              state <= S_FRD;
            end
          end else if (nxt >= (PW+1)'(e)) begin
            group_used[g] <= (gu > here) ? gu - here : '0;
            used_total    <= (used_total > BW'(here)) ? used_total - BW'(here) : '0;
            cnt           <= cnt - BW'(here);
            if (cnt == BW'(here)) begin
              state <= S_FIN;
            end else begin
              g     <= g + 1'b1;
              idx   <= '0;
              state <= S_FSET;
            end
          end else begin
            pos   <= PW'(nxt);
            state <= S_FRD;
          end
        end
        S_FIN: begin
          done               <= 1'b1;
          result.status      <= st;
          result.first_block <= fb;
          result.granted     <= gbba_pkg::GRANT_W'(gr);
          result.free_total  <= ftot;
          state              <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GBBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `GBBA_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while still working")
  `GBBA_ASSERT_NEXT(a_one_strobe, done, !done, "result strobe longer than one cycle")
  `GBBA_ASSERT_SAME(a_grant_ok, done && (result.granted != '0),
                    result.status == gbba_pkg::ST_OK, "blocks granted with error status")
endmodule
